// ===== src/http_request_lexer_core_assert.svh =====
// Assertion macros used by the checker file of the lexer.
`ifndef HTTP_REQUEST_LEXER_CORE_ASSERT_SVH
`define HTTP_REQUEST_LEXER_CORE_ASSERT_SVH

// Same-cycle implication, disabled while reset is low.
`define HLEX_ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is low.
`define HLEX_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/hlex_pkg.sv =====
`default_nettype none

package hlex_pkg;

  // Result kinds
  typedef enum logic [1:0] {
    KIND_APPEND = 2'd0,
    KIND_CLOSE  = 2'd1,
    KIND_END    = 2'd2
  } kind_e;

  // Token classes
  typedef enum logic [2:0] {
    CLS_WORD   = 3'd0,
    CLS_QUOTED = 3'd1,
    CLS_SPACE  = 3'd2,
    CLS_CRLF   = 3'd3,
    CLS_COLON  = 3'd4,
    CLS_SEMI   = 3'd5,
    CLS_SLASH  = 3'd6,
    CLS_QMARK  = 3'd7
  } tok_class_e;

  // Character codes
  localparam logic [7:0] CH_BS     = 8'h08;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_VT     = 8'h0B;
  localparam logic [7:0] CH_FF     = 8'h0C;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_SP     = 8'h20;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_COLON  = 8'h3A;
  localparam logic [7:0] CH_SEMI   = 8'h3B;
  localparam logic [7:0] CH_QMARK  = 8'h3F;

  // Result steps of one byte, in the order they go out
  localparam int STEP_PRE_CR     = 0;  // append CR of a held CR
  localparam int STEP_PRE_LF     = 1;  // append LF of a CRLF
  localparam int STEP_PRE_CLOSE  = 2;  // close held CR as space or CRLF
  localparam int STEP_WORD_CLOSE = 3;  // close open word before a delimiter
  localparam int STEP_APPEND     = 4;  // append the byte itself
  localparam int STEP_CLOSE      = 5;  // close with the byte's class
  localparam int STEP_EOI_CR     = 6;  // append CR held at end of input
  localparam int STEP_EOI_SPACE  = 7;  // close that CR as space
  localparam int STEP_EOI_WORD   = 8;  // close word open at end of input
  localparam int STEP_END        = 9;  // end of request
  localparam int NUM_STEPS       = 10;
  localparam int STEP_W          = $clog2(NUM_STEPS);

  // Lexer state
  typedef struct packed {
    logic skipping;
    logic in_quotes;
    logic word_open;
    logic cr_pending;
    logic last_crlf;
    logic body;
  } lex_state_t;

  localparam lex_state_t LEX_RESET = '{
    skipping:   1'b1,
    in_quotes:  1'b0,
    word_open:  1'b0,
    cr_pending: 1'b0,
    last_crlf:  1'b0,
    body:       1'b0
  };

  // Work plan for one byte, handed from front to back
  typedef struct packed {
    logic [NUM_STEPS-1:0] steps;
    logic [7:0]           data_byte;
    tok_class_e           cls;
    logic                 pre_crlf;
    logic                 qerr;
  } plan_t;

endpackage

`default_nettype wire

// ===== src/hlex_front.sv =====
`default_nettype none

// Classifies each input byte against the lexer state and builds its plan.
module hlex_front (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_ready_o,
  input  wire logic [7:0]    data_byte_i,
  input  wire logic          end_of_input_i,
  output logic               push_o,
  output hlex_pkg::plan_t    plan_o,
  input  wire logic          queue_full_i
);

  hlex_pkg::lex_state_t state_q, state_d;
  hlex_pkg::plan_t      plan;
  logic                 fire;
  logic                 do_handle;
  logic                 lead_ws, is_space, is_delim, is_cr, is_dq;

  assign in_ready_o = !queue_full_i;
  assign fire       = in_valid_i && in_ready_o;

  // Byte classes
  always_comb begin
    lead_ws  = (data_byte_i == hlex_pkg::CH_LF) || (data_byte_i == hlex_pkg::CH_CR) ||
               (data_byte_i == hlex_pkg::CH_TAB) || (data_byte_i == hlex_pkg::CH_BS) ||
               (data_byte_i == hlex_pkg::CH_SP);
    is_space = (data_byte_i == hlex_pkg::CH_SP) || (data_byte_i == hlex_pkg::CH_TAB) ||
               (data_byte_i == hlex_pkg::CH_LF) || (data_byte_i == hlex_pkg::CH_VT) ||
               (data_byte_i == hlex_pkg::CH_FF);
    is_delim = (data_byte_i == hlex_pkg::CH_COLON) || (data_byte_i == hlex_pkg::CH_SEMI) ||
               (data_byte_i == hlex_pkg::CH_SLASH) || (data_byte_i == hlex_pkg::CH_QMARK);
    is_cr    = (data_byte_i == hlex_pkg::CH_CR);
    is_dq    = (data_byte_i == hlex_pkg::CH_DQUOTE);
  end

  // Next state and plan
  always_comb begin
    state_d        = state_q;
    plan           = '0;
    plan.data_byte = data_byte_i;
    plan.cls       = hlex_pkg::CLS_WORD;
    do_handle      = 1'b1;

    // resolve a held CR
    if (state_d.cr_pending) begin
      state_d.cr_pending                  = 1'b0;
      plan.steps[hlex_pkg::STEP_PRE_CR]    = 1'b1;
      plan.steps[hlex_pkg::STEP_PRE_CLOSE] = 1'b1;
      if (data_byte_i == hlex_pkg::CH_LF) begin
        plan.pre_crlf                    = 1'b1;
        plan.steps[hlex_pkg::STEP_PRE_LF] = 1'b1;
        if (state_d.last_crlf) begin
          state_d.body      = 1'b1;
          state_d.word_open = 1'b1;
        end
        state_d.last_crlf = 1'b1;
        do_handle         = 1'b0;
      end else begin
        state_d.last_crlf = 1'b0;
      end
    end

    // the byte itself
    if (do_handle) begin
      if (state_d.body) begin
        plan.steps[hlex_pkg::STEP_APPEND] = 1'b1;
      end else if (!(state_d.skipping && lead_ws)) begin
        state_d.skipping = 1'b0;
        if (state_d.in_quotes) begin
          plan.steps[hlex_pkg::STEP_APPEND] = 1'b1;
          if (is_dq) begin
            plan.steps[hlex_pkg::STEP_CLOSE] = 1'b1;
            plan.cls                         = hlex_pkg::CLS_QUOTED;
            state_d.last_crlf                = 1'b0;
            state_d.word_open                = 1'b0;
            state_d.in_quotes                = 1'b0;
          end
        end else if (is_dq) begin
          state_d.in_quotes                 = 1'b1;
          state_d.word_open                 = 1'b1;
          plan.steps[hlex_pkg::STEP_APPEND] = 1'b1;
        end else if (is_cr || is_space || is_delim) begin
          // delimiter: open word closes first
          if (state_d.word_open) begin
            plan.steps[hlex_pkg::STEP_WORD_CLOSE] = 1'b1;
            state_d.word_open                     = 1'b0;
            state_d.last_crlf                     = 1'b0;
          end
          if (is_cr) begin
            state_d.cr_pending = 1'b1;
          end else begin
            plan.steps[hlex_pkg::STEP_APPEND] = 1'b1;
            plan.steps[hlex_pkg::STEP_CLOSE]  = 1'b1;
            state_d.last_crlf                 = 1'b0;
            case (data_byte_i)
              hlex_pkg::CH_COLON: plan.cls = hlex_pkg::CLS_COLON;
              hlex_pkg::CH_SEMI:  plan.cls = hlex_pkg::CLS_SEMI;
              hlex_pkg::CH_SLASH: plan.cls = hlex_pkg::CLS_SLASH;
              hlex_pkg::CH_QMARK: plan.cls = hlex_pkg::CLS_QMARK;
              default:            plan.cls = hlex_pkg::CLS_SPACE;
            endcase
          end
        end else begin
          plan.steps[hlex_pkg::STEP_APPEND] = 1'b1;
          state_d.word_open                 = 1'b1;
        end
      end
    end

    // end of request: flush and return to reset state
    if (end_of_input_i) begin
      if (state_d.cr_pending) begin
        plan.steps[hlex_pkg::STEP_EOI_CR]    = 1'b1;
        plan.steps[hlex_pkg::STEP_EOI_SPACE] = 1'b1;
      end
      if (state_d.word_open) begin
        plan.steps[hlex_pkg::STEP_EOI_WORD] = 1'b1;
      end
      plan.steps[hlex_pkg::STEP_END] = 1'b1;
      plan.qerr                      = state_d.in_quotes;
      state_d                        = hlex_pkg::LEX_RESET;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= hlex_pkg::LEX_RESET;
    end else if (fire) begin
      state_q <= state_d;
    end
  end

  // bytes that cause nothing are not queued
  assign push_o = fire && (plan.steps != '0);
  assign plan_o = plan;

endmodule

`default_nettype wire

// ===== src/hlex_queue.sv =====
`default_nettype none

// Short queue of plans between front and back.
module hlex_queue #(
  parameter int Depth = 2
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            push_i,
  input  wire hlex_pkg::plan_t wdata_i,
  output logic                 full_o,
  input  wire logic            pop_i,
  output logic                 empty_o,
  output hlex_pkg::plan_t      rdata_o
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  hlex_pkg::plan_t mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;
  logic            do_push, do_pop;

  assign full_o  = (count_q == CntW'(Depth));
  assign empty_o = (count_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign rdata_o = mem_q[rd_ptr_q];

  // Pointer wrap and fill count
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

endmodule

`default_nettype wire

// ===== src/hlex_back.sv =====
`default_nettype none

// Expands one plan into result beats, one step per cycle while the output is ready.
module hlex_back (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            q_empty_i,
  input  wire hlex_pkg::plan_t q_plan_i,
  output logic                 q_pop_o,
  output logic                 out_valid_o,
  input  wire logic            out_ready_i,
  output hlex_pkg::kind_e      kind_o,
  output logic [7:0]           out_byte_o,
  output hlex_pkg::tok_class_e cls_o,
  output logic                 qerr_o,
  output logic                 last_o
);

  logic [hlex_pkg::NUM_STEPS-1:0] steps_q, steps_d, rest;
  logic [7:0]                     byte_q;
  hlex_pkg::tok_class_e           cls_q;
  logic                           pre_crlf_q, qerr_q;
  logic [hlex_pkg::STEP_W-1:0]    sel;
  logic                           fire, load;

  assign out_valid_o = (steps_q != '0);
  assign fire        = out_valid_o && out_ready_i;
  // drop the lowest pending step
  assign rest        = steps_q & (steps_q - 1'b1);
  assign last_o      = (rest == '0);
  assign load        = !q_empty_i && (!out_valid_o || (fire && last_o));
  assign q_pop_o     = load;

  // Lowest pending step
  always_comb begin
    sel = '0;
    for (int i = hlex_pkg::NUM_STEPS - 1; i >= 0; i--) begin
      if (steps_q[i]) begin
        sel = hlex_pkg::STEP_W'(i);
      end
    end
  end

  // Result of the selected step
  always_comb begin
    kind_o     = hlex_pkg::KIND_CLOSE;
    out_byte_o = 8'h00;
    cls_o      = hlex_pkg::CLS_WORD;
    qerr_o     = 1'b0;
    case (sel)
      hlex_pkg::STEP_W'(hlex_pkg::STEP_PRE_CR),
      hlex_pkg::STEP_W'(hlex_pkg::STEP_EOI_CR): begin
        kind_o     = hlex_pkg::KIND_APPEND;
        out_byte_o = hlex_pkg::CH_CR;
      end
      hlex_pkg::STEP_W'(hlex_pkg::STEP_PRE_LF): begin
        kind_o     = hlex_pkg::KIND_APPEND;
        out_byte_o = hlex_pkg::CH_LF;
      end
      hlex_pkg::STEP_W'(hlex_pkg::STEP_PRE_CLOSE): begin
        cls_o = pre_crlf_q ? hlex_pkg::CLS_CRLF : hlex_pkg::CLS_SPACE;
      end
      hlex_pkg::STEP_W'(hlex_pkg::STEP_WORD_CLOSE),
      hlex_pkg::STEP_W'(hlex_pkg::STEP_EOI_WORD): begin
        cls_o = hlex_pkg::CLS_WORD;
      end
      hlex_pkg::STEP_W'(hlex_pkg::STEP_APPEND): begin
        kind_o     = hlex_pkg::KIND_APPEND;
        out_byte_o = byte_q;
      end
      hlex_pkg::STEP_W'(hlex_pkg::STEP_CLOSE): begin
        cls_o = cls_q;
      end
      hlex_pkg::STEP_W'(hlex_pkg::STEP_EOI_SPACE): begin
        cls_o = hlex_pkg::CLS_SPACE;
      end
      hlex_pkg::STEP_W'(hlex_pkg::STEP_END): begin
        kind_o = hlex_pkg::KIND_END;
        qerr_o = qerr_q;
      end
      default: begin
        kind_o = hlex_pkg::KIND_CLOSE;
      end
    endcase
  end

  // Pending step mask
  always_comb begin
    steps_d = steps_q;
    if (load) begin
      steps_d = q_plan_i.steps;
    end else if (fire) begin
      steps_d = rest;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      steps_q <= '0;
    end else begin
      steps_q <= steps_d;
    end
  end

  // Plan payload
  always_ff @(posedge clk_i) begin
    if (load) begin
      byte_q     <= q_plan_i.data_byte;
      cls_q      <= q_plan_i.cls;
      pre_crlf_q <= q_plan_i.pre_crlf;
      qerr_q     <= q_plan_i.qerr;
    end
  end

endmodule

`default_nettype wire

// ===== src/http_request_lexer_core.sv =====
// Channel  | Dir | tdata                                      | tuser        | tlast
// s_axis   | in  | [7:0] data_byte                            | -            | end_of_input
// m_axis   | out | [7:0] out_byte, [10:8] token_class,        | [1:0] kind   | last result
//          |     | [11] quote_error, [15:12] zero             |              |   of a byte
//
// A byte is classified and its plan queued in the cycle it is accepted; an idle expander
// loads the plan at the next edge and offers the first result from its step register.
// Results leave one per cycle while the output is ready, so a byte with n results (n from
// 0 to 5) takes n output beats and the output beat rate sets throughput. The plan queue
// (QueueDepth entries) lets input run on while the output stalls; input stalls only when
// it is full. Reset clears lexer state, queue and expander at once.
`default_nettype none

module http_request_lexer_core #(
  parameter int QueueDepth = 2
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,   // [7:0] data_byte
  input  wire logic        s_axis_tlast,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [15:0]      m_axis_tdata,   // [7:0] out_byte, [10:8] token_class,
                                           // [11] quote_error, [15:12] zero
  output logic [1:0]       m_axis_tuser,   // [1:0] result_kind
  output logic             m_axis_tlast
);

  hlex_pkg::plan_t      push_plan, head_plan;
  logic                 push, full, empty, pop;
  hlex_pkg::kind_e      kind;
  logic [7:0]           out_byte;
  hlex_pkg::tok_class_e cls;
  logic                 qerr;

  hlex_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (s_axis_tvalid),
    .in_ready_o     (s_axis_tready),
    .data_byte_i    (s_axis_tdata),
    .end_of_input_i (s_axis_tlast),
    .push_o         (push),
    .plan_o         (push_plan),
    .queue_full_i   (full)
  );

  hlex_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i (push_plan),
    .full_o  (full),
    .pop_i   (pop),
    .empty_o (empty),
    .rdata_o (head_plan)
  );

  hlex_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_empty_i   (empty),
    .q_plan_i    (head_plan),
    .q_pop_o     (pop),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .kind_o      (kind),
    .out_byte_o  (out_byte),
    .cls_o       (cls),
    .qerr_o      (qerr),
    .last_o      (m_axis_tlast)
  );

  // Output beat packing
  assign m_axis_tdata = {4'b0000, qerr, cls, out_byte};
  assign m_axis_tuser = kind;

endmodule

`default_nettype wire

// ===== src/hlex_checker.sv =====
`default_nettype none

`include "http_request_lexer_core_assert.svh"

// Port-level checks on the lexer's result stream.
module hlex_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic [15:0] m_axis_tdata,
  input wire logic [1:0]  m_axis_tuser,
  input wire logic        m_axis_tlast
);

  logic [19:0] beat;
  logic        stall;
  logic        end_beat, end_ok;
  logic        app_beat, app_ok;
  logic        close_beat, close_ok;

  // Terms of the checks
  assign beat       = {m_axis_tvalid, m_axis_tlast, m_axis_tuser, m_axis_tdata};
  assign stall      = m_axis_tvalid && !m_axis_tready;
  assign end_beat   = m_axis_tvalid && (m_axis_tuser == hlex_pkg::KIND_END);
  assign end_ok     = m_axis_tlast && (m_axis_tdata[10:0] == 11'd0);
  assign app_beat   = m_axis_tvalid && (m_axis_tuser == hlex_pkg::KIND_APPEND);
  assign app_ok     = (m_axis_tdata[15:8] == 8'd0);
  assign close_beat = m_axis_tvalid && (m_axis_tuser == hlex_pkg::KIND_CLOSE);
  assign close_ok   = (m_axis_tdata[7:0] == 8'd0) && (m_axis_tdata[15:11] == 5'd0);

  // stalled beat holds
  `HLEX_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, stall, $stable(beat), "stalled beat changed")

  // end of request is always the final beat of its byte and carries no byte and no class
  `HLEX_ASSERT_IMPL(a_end_last, clk_i, rst_ni, end_beat, end_ok, "end beat not last or dirty")

  // append beats carry no class and no quote flag
  `HLEX_ASSERT_IMPL(a_append_clean, clk_i, rst_ni, app_beat, app_ok, "append beat dirty")

  // close beats carry no byte and no quote flag
  `HLEX_ASSERT_IMPL(a_close_clean, clk_i, rst_ni, close_beat, close_ok, "close beat dirty")

endmodule

bind http_request_lexer_core hlex_checker u_hlex_checker (.*);

`default_nettype wire
